// ===== rtl/particle_velocity_position_update_defines.svh =====
// ---------------------------------------------------------------------------
// Particle velocity and position update: assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_VELOCITY_POSITION_UPDATE_DEFINES_SVH
`define PARTICLE_VELOCITY_POSITION_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVPU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvpu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PVPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvpu assertion failed");

`endif

// ===== rtl/pvpu_pkg.sv =====
// ---------------------------------------------------------------------------
// Particle velocity and position update package
// Widths, codes, pipeline payload types and the saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvpu_pkg;

    localparam int VALUE_W    = 32;
    localparam int STEP_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int RAND_W     = 16;
    localparam int EV_W       = 2;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = VALUE_W + 1;
    localparam int PROD_W     = GAIN_W + STEP_W + 1;
    localparam int MUL_W      = GAIN_W + 1 + DIFF_W;
    localparam int DIV_STAGES = GAIN_W;
    localparam int WRAP_STAGES = VALUE_W;
    localparam int MAG_W      = VALUE_W + 1;
    localparam int REM_W      = VALUE_W + 2;

    localparam logic [EV_W-1:0] EV_INSIDE = 2'd0;
    localparam logic [EV_W-1:0] EV_BELOW  = 2'd1;
    localparam logic [EV_W-1:0] EV_ABOVE  = 2'd2;

    localparam logic [2:0] REG_COG   = 3'd0;
    localparam logic [2:0] REG_SOC   = 3'd1;
    localparam logic [2:0] REG_WMAX  = 3'd2;
    localparam logic [2:0] REG_WMIN  = 3'd3;
    localparam logic [2:0] REG_STEPS = 3'd4;
    localparam logic [2:0] REG_CLAMP = 3'd5;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        logic signed [MUL_W-1:0]   m1;
        logic signed [MUL_W-1:0]   m2;
        logic [PROD_W-1:0]         rem;
        logic [GAIN_W-1:0]         q;
        logic                      neg;
        logic                      wmin_sel;
    } inertia_t;

    typedef struct packed {
        logic [EV_W-1:0]           ev;
        logic signed [VALUE_W-1:0] np;
        logic signed [VALUE_W-1:0] nv;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0]        dvd;
        logic [MAG_W-1:0]          mag;
        logic [REM_W-1:0]          rem;
    } wrap_t;

    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [63:0] a);
        logic signed [VALUE_W-1:0] r;
        if (a > SAT_HI)
        begin
            r = SAT_HI[VALUE_W-1:0];
        end
        else if (a < SAT_LO)
        begin
            r = SAT_LO[VALUE_W-1:0];
        end
        else
        begin
            r = a[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pvpu_in_if.sv =====
// ---------------------------------------------------------------------------
// Particle velocity and position update: input channel
// Valid/ready channel that carries one particle dimension per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvpu_in_if;
    import pvpu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STEP_W-1:0]         step_number;
    logic signed [VALUE_W-1:0] position;
    logic signed [VALUE_W-1:0] velocity;
    logic signed [VALUE_W-1:0] personal_best;
    logic signed [VALUE_W-1:0] neighbor_best;
    logic signed [VALUE_W-1:0] lower_bound;
    logic signed [VALUE_W-1:0] upper_bound;
    logic [RAND_W-1:0]         random_one;
    logic [RAND_W-1:0]         random_two;

    modport source (output valid, step_number, position, velocity, personal_best,
                    neighbor_best, lower_bound, upper_bound, random_one, random_two,
                    input ready);
    modport sink (input valid, step_number, position, velocity, personal_best,
                  neighbor_best, lower_bound, upper_bound, random_one, random_two,
                  output ready);
endinterface

// ===== rtl/pvpu_out_if.sv =====
// ---------------------------------------------------------------------------
// Particle velocity and position update: output channel
// Valid/ready channel that carries one updated dimension per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvpu_out_if;
    import pvpu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] new_position;
    logic signed [VALUE_W-1:0] new_velocity;
    logic [EV_W-1:0]           bound_event;

    modport source (output valid, new_position, new_velocity, bound_event, input ready);
    modport sink (input valid, new_position, new_velocity, bound_event, output ready);
endinterface

// ===== rtl/pvpu_wrap.sv =====
// ---------------------------------------------------------------------------
// Periodic wrap remainder pipeline
// Restoring remainder of the overshoot by the span, one bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvpu_wrap (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  pvpu_pkg::wrap_t  in_data,
    output logic             out_valid,
    output pvpu_pkg::wrap_t  out_data
);
    import pvpu_pkg::*;

    wrap_t st_reg   [0:WRAP_STAGES];
    logic  vld_reg  [0:WRAP_STAGES];

    assign st_reg[0]  = in_data;
    assign vld_reg[0] = in_valid;

    for (genvar k = 0; k < WRAP_STAGES; k++)
    begin : g_stage
        wrap_t            st_next;
        logic [REM_W-1:0] r;

        always_comb
        begin
            st_next = st_reg[k];
            r = {st_reg[k].rem[REM_W-2:0], st_reg[k].dvd[WRAP_STAGES-1-k]};
            if (r >= REM_W'(st_reg[k].mag))
            begin
                r = r - REM_W'(st_reg[k].mag);
            end
            st_next.rem = r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k+1] <= st_next;
            end
        end
    end

    assign out_valid = vld_reg[WRAP_STAGES];
    assign out_data  = st_reg[WRAP_STAGES];

endmodule

// ===== rtl/particle_velocity_position_update.sv =====
// ---------------------------------------------------------------------------
// Particle velocity and position update
// One particle dimension per transfer: inertia, velocity, position, bounds.
// ---------------------------------------------------------------------------
// The block takes one particle dimension per cycle; the pipeline accepts a
// new transfer every cycle unless the output side holds back, which stalls
// all stages together. Most of the pipeline lies in the 16-stage restoring
// divider that forms the inertia weight and the 32-stage remainder pipeline
// used for periodic wrapping.
`timescale 1ns / 1ps

`include "particle_velocity_position_update_defines.svh"

module particle_velocity_position_update (
    input  logic                          clk,
    input  logic                          rst_n,
    pvpu_in_if.sink                       item_in,
    pvpu_out_if.source                    item_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvpu_pkg::ADDR_W-1:0]   paddr,
    input  logic [pvpu_pkg::DATA_W-1:0]   pwdata,
    output logic [pvpu_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pvpu_pkg::*;

    logic [GAIN_W-1:0] cog_reg, soc_reg, wmax_reg, wmin_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              clamp_reg;

    logic              wr_en;
    logic [2:0]        reg_idx;
    logic [STEP_W+1:0] steps3;
    logic [STEP_W-1:0] dec;
    logic              adv;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cog_reg   <= 16'd24511;
            soc_reg   <= 16'd24511;
            wmax_reg  <= 16'd11957;
            wmin_reg  <= 16'd4915;
            steps_reg <= 24'd100000;
            clamp_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_COG:   cog_reg   <= pwdata[GAIN_W-1:0];
                REG_SOC:   soc_reg   <= pwdata[GAIN_W-1:0];
                REG_WMAX:  wmax_reg  <= pwdata[GAIN_W-1:0];
                REG_WMIN:  wmin_reg  <= pwdata[GAIN_W-1:0];
                REG_STEPS: steps_reg <= pwdata[STEP_W-1:0];
                REG_CLAMP: clamp_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COG:   prdata = DATA_W'(cog_reg);
            REG_SOC:   prdata = DATA_W'(soc_reg);
            REG_WMAX:  prdata = DATA_W'(wmax_reg);
            REG_WMIN:  prdata = DATA_W'(wmin_reg);
            REG_STEPS: prdata = DATA_W'(steps_reg);
            REG_CLAMP: prdata = DATA_W'(clamp_reg);
            default:   prdata = '0;
        endcase
    end

    // The decrement stage is three quarters of the run, rounded down.
    assign steps3 = {1'b0, steps_reg, 1'b0} + (STEP_W+2)'(steps_reg);
    assign dec    = steps3[STEP_W+1:2];

    logic out_valid_reg;
    assign adv           = !out_valid_reg || item_out.ready;
    assign item_in.ready = adv;

    // Stage A: gain fractions, differences and the inertia numerator.
    logic                      a_valid_reg;
    logic signed [VALUE_W-1:0] a_x_reg, a_v_reg, a_lo_reg, a_hi_reg;
    logic [GAIN_W-1:0]         a_rho1_reg, a_rho2_reg;
    logic signed [DIFF_W-1:0]  a_d1_reg, a_d2_reg;
    logic [PROD_W-1:0]         a_prod_reg;
    logic                      a_neg_reg, a_wsel_reg;

    logic [2*GAIN_W-1:0] rho1_full, rho2_full;
    logic [GAIN_W-1:0]   dmag;
    logic [STEP_W-1:0]   ds;
    logic                wneg;

    always_comb
    begin
        rho1_full = (2*GAIN_W)'(cog_reg) * (2*GAIN_W)'(item_in.random_one);
        rho2_full = (2*GAIN_W)'(soc_reg) * (2*GAIN_W)'(item_in.random_two);
        wneg      = wmax_reg < wmin_reg;
        dmag      = wneg ? (wmin_reg - wmax_reg) : (wmax_reg - wmin_reg);
        ds        = dec - item_in.step_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg    <= item_in.position;
            a_v_reg    <= item_in.velocity;
            a_lo_reg   <= item_in.lower_bound;
            a_hi_reg   <= item_in.upper_bound;
            a_rho1_reg <= rho1_full[2*GAIN_W-1:GAIN_W];
            a_rho2_reg <= rho2_full[2*GAIN_W-1:GAIN_W];
            a_d1_reg   <= DIFF_W'(item_in.personal_best) - DIFF_W'(item_in.position);
            a_d2_reg   <= DIFF_W'(item_in.neighbor_best) - DIFF_W'(item_in.position);
            a_prod_reg <= PROD_W'(dmag) * PROD_W'(ds);
            a_neg_reg  <= wneg;
            a_wsel_reg <= (dec == '0) || (item_in.step_number > dec);
        end
    end

    // Stage B and the inertia divider: quotient of the numerator by dec.
    inertia_t div_reg  [0:DIV_STAGES];
    logic     dvld_reg [0:DIV_STAGES];
    inertia_t b_next;

    always_comb
    begin
        b_next.x        = a_x_reg;
        b_next.v        = a_v_reg;
        b_next.lo       = a_lo_reg;
        b_next.hi       = a_hi_reg;
        b_next.m1       = MUL_W'(signed'({1'b0, a_rho1_reg})) * MUL_W'(a_d1_reg);
        b_next.m2       = MUL_W'(signed'({1'b0, a_rho2_reg})) * MUL_W'(a_d2_reg);
        b_next.rem      = a_prod_reg;
        b_next.q        = '0;
        b_next.neg      = a_neg_reg;
        b_next.wmin_sel = a_wsel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dvld_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= b_next;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int BIT = DIV_STAGES - 1 - k;
        inertia_t          div_next;
        logic [PROD_W-1:0] dsh;

        always_comb
        begin
            div_next = div_reg[k];
            dsh      = PROD_W'(dec) << BIT;
            if (div_reg[k].rem >= dsh)
            begin
                div_next.rem    = div_reg[k].rem - dsh;
                div_next.q[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dvld_reg[k+1] <= dvld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k+1] <= div_next;
            end
        end
    end

    // Stage C: inertia weight and the sum of the attraction terms.
    inertia_t                  dq;
    logic                      c_valid_reg;
    logic [GAIN_W-1:0]         c_w_reg;
    logic signed [VALUE_W-1:0] c_x_reg, c_v_reg, c_lo_reg, c_hi_reg;
    logic signed [MUL_W:0]     c_psum_reg;
    logic [GAIN_W-1:0]         w_next;

    assign dq = div_reg[DIV_STAGES];

    always_comb
    begin
        if (dq.wmin_sel)
        begin
            w_next = wmin_reg;
        end
        else if (dq.neg)
        begin
            w_next = wmin_reg - dq.q;
        end
        else
        begin
            w_next = wmin_reg + dq.q;
        end
    end

    // Stage D: inertia term. Stage E: velocity. Stage F: position and span.
    logic                      d_valid_reg, e_valid_reg, f_valid_reg;
    logic signed [MUL_W-2:0]   d_m0_reg;
    logic signed [MUL_W:0]     d_psum_reg;
    logic signed [VALUE_W-1:0] d_x_reg, d_lo_reg, d_hi_reg;
    logic signed [VALUE_W-1:0] e_nv_reg, e_x_reg, e_lo_reg, e_hi_reg;
    logic signed [VALUE_W-1:0] f_np_reg, f_nv_reg, f_lo_reg, f_hi_reg;
    logic signed [DIFF_W-1:0]  f_span_reg;
    logic signed [MUL_W+1:0]   acc;
    logic signed [MUL_W-13:0]  acc_sh;

    always_comb
    begin
        acc    = (MUL_W+2)'(d_m0_reg) + (MUL_W+2)'(d_psum_reg);
        acc_sh = acc[MUL_W+1:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= dvld_reg[DIV_STAGES];
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_w_reg    <= w_next;
            c_x_reg    <= dq.x;
            c_v_reg    <= dq.v;
            c_lo_reg   <= dq.lo;
            c_hi_reg   <= dq.hi;
            c_psum_reg <= (MUL_W+1)'(dq.m1) + (MUL_W+1)'(dq.m2);

            d_m0_reg   <= (MUL_W-1)'(signed'({1'b0, c_w_reg})) * (MUL_W-1)'(c_v_reg);
            d_psum_reg <= c_psum_reg;
            d_x_reg    <= c_x_reg;
            d_lo_reg   <= c_lo_reg;
            d_hi_reg   <= c_hi_reg;

            e_nv_reg   <= sat_value(64'(acc_sh));
            e_x_reg    <= d_x_reg;
            e_lo_reg   <= d_lo_reg;
            e_hi_reg   <= d_hi_reg;

            f_np_reg   <= sat_value(64'(e_x_reg) + 64'(e_nv_reg));
            f_nv_reg   <= e_nv_reg;
            f_lo_reg   <= e_lo_reg;
            f_hi_reg   <= e_hi_reg;
            f_span_reg <= DIFF_W'(e_hi_reg) - DIFF_W'(e_lo_reg);
        end
    end

    // Stage G: bound test and the wrap operands.
    logic  g_valid_reg;
    wrap_t g_reg;
    wrap_t g_next;
    logic  below, above;

    always_comb
    begin
        below      = f_np_reg < f_lo_reg;
        above      = f_np_reg > f_hi_reg;
        g_next.np  = f_np_reg;
        g_next.nv  = f_nv_reg;
        g_next.lo  = f_lo_reg;
        g_next.hi  = f_hi_reg;
        g_next.rem = '0;
        g_next.mag = f_span_reg[DIFF_W-1] ? MAG_W'(-f_span_reg) : MAG_W'(f_span_reg);
        if (below)
        begin
            g_next.ev  = EV_BELOW;
            g_next.dvd = VALUE_W'(f_lo_reg - f_np_reg);
        end
        else if (above)
        begin
            g_next.ev  = EV_ABOVE;
            g_next.dvd = VALUE_W'(f_np_reg - f_hi_reg);
        end
        else
        begin
            g_next.ev  = EV_INSIDE;
            g_next.dvd = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg <= g_next;
        end
    end

    logic  w_valid;
    wrap_t w_data;

    pvpu_wrap u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (g_valid_reg),
        .in_data   (g_reg),
        .out_valid (w_valid),
        .out_data  (w_data)
    );

    // Output register: bound handling and the final result.
    logic signed [VALUE_W-1:0] out_np_reg, out_nv_reg;
    logic [EV_W-1:0]           out_ev_reg;
    logic signed [VALUE_W-1:0] np_next, nv_next;
    logic [MAG_W-1:0]          rem_fin;

    always_comb
    begin
        rem_fin = w_data.rem[MAG_W-1:0];
        np_next = w_data.np;
        nv_next = w_data.nv;
        if (w_data.ev != EV_INSIDE)
        begin
            nv_next = '0;
            if (clamp_reg)
            begin
                np_next = (w_data.ev == EV_BELOW) ? w_data.lo : w_data.hi;
            end
            else if (w_data.mag == '0)
            begin
                np_next = w_data.lo;
            end
            else if (w_data.ev == EV_BELOW)
            begin
                np_next = sat_value(64'(w_data.hi) - signed'(64'(rem_fin)));
            end
            else
            begin
                np_next = sat_value(64'(w_data.lo) + signed'(64'(rem_fin)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= w_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_np_reg <= np_next;
            out_nv_reg <= nv_next;
            out_ev_reg <= w_data.ev;
        end
    end

    assign item_out.valid        = out_valid_reg;
    assign item_out.new_position = out_np_reg;
    assign item_out.new_velocity = out_nv_reg;
    assign item_out.bound_event  = out_ev_reg;

    `PVPU_ASSERT_IMPLIES(a_evt_vel_zero, clk, rst_n, item_out.valid && item_out.bound_event != EV_INSIDE, item_out.new_velocity == '0)
    `PVPU_ASSERT_IMPLIES(a_evt_code, clk, rst_n, item_out.valid, item_out.bound_event == EV_INSIDE || item_out.bound_event == EV_BELOW || item_out.bound_event == EV_ABOVE)
    `PVPU_ASSERT_NEXT(a_accept_enters, clk, rst_n, item_in.valid && item_in.ready, a_valid_reg)

endmodule

// ===== tb/particle_velocity_position_update_test.sv =====
// ---------------------------------------------------------------------------
// Particle velocity and position update: testbench
// Streams particle dimensions through the block under several gain, inertia
// and bound-handling settings, predicts each updated dimension in the bench
// and compares every output transfer field by field, with random idling on
// both channels and one long output hold that backs up the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_velocity_position_update_test;
    import pvpu_pkg::*;

    typedef struct {
        logic [STEP_W-1:0]         step;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] pb;
        logic signed [VALUE_W-1:0] nb;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        logic [RAND_W-1:0]         r1;
        logic [RAND_W-1:0]         r2;
    } dim_t;

    typedef struct {
        logic signed [VALUE_W-1:0] np;
        logic signed [VALUE_W-1:0] nv;
        logic [EV_W-1:0]           ev;
    } upd_t;

    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pvpu_in_if  in_ch();
    pvpu_out_if out_ch();

    particle_velocity_position_update u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (in_ch),
        .item_out(out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [GAIN_W-1:0] cfg_cog;
    logic [GAIN_W-1:0] cfg_soc;
    logic [GAIN_W-1:0] cfg_wmax;
    logic [GAIN_W-1:0] cfg_wmin;
    logic [STEP_W-1:0] cfg_steps;
    logic              cfg_clamp;

    dim_t pending_dims[$];
    upd_t expected_upds[$];
    int   fails;
    bit   idle_on;
    bit   long_hold_req;
    bit   hold_used;
    int   hold_cnt;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint clip32(input longint a);
        if (a > longint'(VMAX))
        begin
            return longint'(VMAX);
        end
        if (a < longint'(VMIN))
        begin
            return longint'(VMIN);
        end
        return a;
    endfunction

    function automatic upd_t update_dim(input dim_t d);
        longint dec;
        longint wgt;
        longint rho1;
        longint rho2;
        longint acc;
        longint nv;
        longint np;
        longint lo;
        longint hi;
        longint mag;
        upd_t   r;
        dec = (3 * longint'(cfg_steps)) / 4;
        if (dec == 0 || longint'(d.step) > dec)
        begin
            wgt = longint'(cfg_wmin);
        end
        else
        begin
            wgt = longint'(cfg_wmin) + ((longint'(cfg_wmax) - longint'(cfg_wmin))
                  * (dec - longint'(d.step))) / dec;
        end
        rho1 = (longint'(cfg_cog) * longint'(d.r1)) >>> 16;
        rho2 = (longint'(cfg_soc) * longint'(d.r2)) >>> 16;
        acc = wgt * longint'(d.v) + rho1 * (longint'(d.pb) - longint'(d.x))
              + rho2 * (longint'(d.nb) - longint'(d.x));
        nv = clip32(acc >>> 14);
        np = clip32(longint'(d.x) + nv);
        lo = longint'(d.lo);
        hi = longint'(d.hi);
        r.ev = EV_INSIDE;
        if (np < lo || np > hi)
        begin
            r.ev = (np < lo) ? EV_BELOW : EV_ABOVE;
            mag = (hi - lo < 0) ? lo - hi : hi - lo;
            if (cfg_clamp)
            begin
                np = (np < lo) ? lo : hi;
            end
            else if (mag == 0)
            begin
                np = lo;
            end
            else if (np < lo)
            begin
                np = clip32(hi - ((lo - np) % mag));
            end
            else
            begin
                np = clip32(lo + ((np - hi) % mag));
            end
            nv = 0;
        end
        r.np = np[31:0];
        r.nv = nv[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 65)
        begin
            return 0;
        end
        if (p < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Input side: a new dimension is loaded when the channel slot is free and no idle gap is pending.
    always @(posedge clk or negedge rst_n)
    begin
        int   gap;
        dim_t d;
        dim_t sent;
        if (!rst_n)
        begin
            gap = 0;
            in_ch.valid <= 1'b0;
            in_ch.step_number <= '0;
            in_ch.position <= '0;
            in_ch.velocity <= '0;
            in_ch.personal_best <= '0;
            in_ch.neighbor_best <= '0;
            in_ch.lower_bound <= '0;
            in_ch.upper_bound <= '0;
            in_ch.random_one <= '0;
            in_ch.random_two <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sent.step = in_ch.step_number;
                sent.x = in_ch.position;
                sent.v = in_ch.velocity;
                sent.pb = in_ch.personal_best;
                sent.nb = in_ch.neighbor_best;
                sent.lo = in_ch.lower_bound;
                sent.hi = in_ch.upper_bound;
                sent.r1 = in_ch.random_one;
                sent.r2 = in_ch.random_two;
                expected_upds.push_back(update_dim(sent));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_dims.size() > 0)
                begin
                    d = pending_dims.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.step_number <= d.step;
                    in_ch.position <= d.x;
                    in_ch.velocity <= d.v;
                    in_ch.personal_best <= d.pb;
                    in_ch.neighbor_best <= d.nb;
                    in_ch.lower_bound <= d.lo;
                    in_ch.upper_bound <= d.hi;
                    in_ch.random_one <= d.r1;
                    in_ch.random_two <= d.r2;
                    gap = pick_gap();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_used <= 1'b0;
        end
        else if (long_hold_req && !hold_used)
        begin
            hold_cnt <= 400;
            hold_used <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Output side: checks each transfer and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        int   stall;
        upd_t e;
        if (!rst_n)
        begin
            stall = 0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_upds.size() == 0)
                begin
                    $error("unexpected transfer on the output channel");
                    fails++;
                end
                else
                begin
                    e = expected_upds.pop_front();
                    if (out_ch.new_position !== e.np)
                    begin
                        $error("new_position expected %0d actual %0d", e.np,
                               out_ch.new_position);
                        fails++;
                    end
                    if (out_ch.new_velocity !== e.nv)
                    begin
                        $error("new_velocity expected %0d actual %0d", e.nv,
                               out_ch.new_velocity);
                        fails++;
                    end
                    if (out_ch.bound_event !== e.ev)
                    begin
                        $error("bound_event expected %0d actual %0d", e.ev,
                               out_ch.bound_event);
                        fails++;
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 15)
                begin
                    stall = pick_gap();
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COG:   cfg_cog = value[15:0];
            REG_SOC:   cfg_soc = value[15:0];
            REG_WMAX:  cfg_wmax = value[15:0];
            REG_WMIN:  cfg_wmin = value[15:0];
            REG_STEPS: cfg_steps = value[23:0];
            REG_CLAMP: cfg_clamp = value[0];
            default:   ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] cog, input logic [31:0] soc,
                              input logic [31:0] wmax, input logic [31:0] wmin,
                              input logic [31:0] steps, input logic [31:0] clamp);
        write_reg(REG_COG, cog);
        write_reg(REG_SOC, soc);
        write_reg(REG_WMAX, wmax);
        write_reg(REG_WMIN, wmin);
        write_reg(REG_STEPS, steps);
        write_reg(REG_CLAMP, clamp);
    endtask

    task automatic drain();
        while (pending_dims.size() > 0 || in_ch.valid || expected_upds.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic add_dim(input logic [23:0] step, input logic [31:0] x,
                           input logic [31:0] v, input logic [31:0] pb,
                           input logic [31:0] nb, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [15:0] r1,
                           input logic [15:0] r2);
        dim_t d;
        d.step = step;
        d.x = x;
        d.v = v;
        d.pb = pb;
        d.nb = nb;
        d.lo = lo;
        d.hi = hi;
        d.r1 = r1;
        d.r2 = r2;
        pending_dims.push_back(d);
    endtask

    // Mostly a particle inside sensible bounds; some fully random noise.
    function automatic logic [31:0] small_val(input int bits);
        logic [31:0] m;
        m = $urandom_range(0, (1 << bits) - 1);
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    task automatic add_random(input int count);
        int          k;
        int          p;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [23:0] step;
        for (k = 0; k < count; k++)
        begin
            p = $urandom_range(0, 99);
            step = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                   : 24'($urandom_range(0, int'(cfg_steps)));
            if (p < 75)
            begin
                lo = small_val(24);
                hi = lo + $urandom_range(0, 1 << 24);
                add_dim(step, lo + $urandom_range(0, hi - lo), small_val(22),
                        lo + small_val(23), lo + small_val(23), lo, hi,
                        16'($urandom), 16'($urandom));
            end
            else
            begin
                add_dim(24'($urandom), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        fails = 0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_cog = 16'd24511;
        cfg_soc = 16'd24511;
        cfg_wmax = 16'd11957;
        cfg_wmin = 16'd4915;
        cfg_steps = 24'd100000;
        cfg_clamp = 1'b1;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_dim(24'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_dim(24'd0, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'hFFFF_0000,
                32'hFFF0_0000, 32'h0010_0000, 16'hFFFF, 16'hFFFF);
        add_dim(24'd75000, 32'h0001_0000, 32'h0010_0000, 0, 0,
                32'hFFF0_0000, 32'h0100_0000, 16'h8000, 16'h0001);
        add_dim(24'd75001, 32'h0001_0000, 32'h0010_0000, 0, 0,
                32'hFFF0_0000, 32'h0100_0000, 16'h8000, 16'h0001);
        add_dim(24'hFFFFFF, 32'h0001_0000, 32'h0010_0000, 0, 0,
                32'hFFF0_0000, 32'h0100_0000, 0, 0);
        add_dim(24'd0, VMAX, VMAX, VMAX, VMAX, VMIN, VMAX, 16'hFFFF, 16'hFFFF);
        add_dim(24'd0, VMIN, VMIN, VMIN, VMIN, VMIN, VMAX, 16'hFFFF, 16'hFFFF);
        add_dim(24'd0, VMIN, VMAX, VMAX, VMAX, VMIN, VMAX, 16'hFFFF, 16'hFFFF);
        add_dim(24'd0, VMAX, VMIN, VMIN, VMIN, VMIN, VMAX, 16'hFFFF, 16'hFFFF);
        add_dim(24'd10, 0, 32'hFFF0_0000, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
        add_dim(24'd10, 0, 32'h0010_0000, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
        add_dim(24'd10, 0, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 0);
        add_dim(24'd10, 32'h0000_8000, 0, 0, 0, 32'h0000_8000, 32'h0000_8000, 0, 0);
        drain();

        set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 5000),
                   $urandom);
        idle_on = 1'b0;
        add_random(100);
        drain();
        idle_on = 1'b1;
        add_random(120);
        drain();

        set_config($urandom, $urandom, $urandom, $urandom, $urandom, 0);
        add_dim(24'd0, 0, 32'hFFF0_0000, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
        add_dim(24'd0, 0, 32'h0010_0000, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
        add_dim(24'd0, 0, 32'h0010_0000, 0, 0, 32'h0000_4000, 32'h0000_4000, 0, 0);
        add_dim(24'd0, 0, VMAX, 0, 0, VMIN, VMAX, 0, 0);
        add_dim(24'd0, 0, 32'h0010_0000, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 0);
        long_hold_req = 1'b1;
        add_random(180);
        drain();

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_random(150);
        drain();

        set_config(0, 0, 0, 32'hFFFF, 0, 1);
        add_random(60);
        drain();
        write_reg(REG_STEPS, 1);
        add_random(60);
        drain();

        if (fails == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
